/* hw/rtl/inode_handle_namespace_map_macros.svh */
// Assertion macros for the inode handle namespace map checker.
`ifndef INODE_HANDLE_NAMESPACE_MAP_MACROS_SVH
`define INODE_HANDLE_NAMESPACE_MAP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define IHNM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define IHNM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ihnm_pkg.sv */
// Shared types and constants for the inode handle namespace map.
`timescale 1ns / 1ps

package ihnm_pkg;

   localparam int NUM_VOLUMES_DEF     = 16;
   localparam int MAPS_PER_VOLUME_DEF = 16;

   localparam int CNT_W     = 5;
   localparam int VOL_W     = 4;
   localparam int INODE_W   = 24;
   localparam int DEV_W     = 16;
   localparam int NS_W      = 8;
   localparam int HANDLE_W  = 32;
   localparam int PAIR_W    = DEV_W + NS_W;
   localparam int IDX_LSB   = 28;
   localparam int IDX_W     = HANDLE_W - IDX_LSB;

   localparam logic [1:0] RES_FAIL = 2'd0;
   localparam logic [1:0] RES_FWD  = 2'd1;
   localparam logic [1:0] RES_REV  = 2'd2;

   typedef struct packed {
      logic                cmd;
      logic [VOL_W-1:0]    volume;
      logic [INODE_W-1:0]  inode;
      logic [DEV_W-1:0]    dev;
      logic [NS_W-1:0]     name_space;
      logic [HANDLE_W-1:0] handle;
   } req_word_type;

   typedef struct packed {
      logic                ok;
      logic [HANDLE_W-1:0] handle_out;
      logic [INODE_W-1:0]  inode_out;
      logic [DEV_W-1:0]    dev_out;
      logic [NS_W-1:0]     name_space_out;
   } rsp_word_type;

   typedef struct packed {
      logic       load_req;
      logic       load_cnt;
      logic       inc_k;
      logic       wr_pair;
      logic       load_rsp;
      logic [1:0] rsp_kind;
   } ihnm_cmd_type;

   typedef struct packed {
      logic reject;
      logic is_rev;
      logic rev_hit;
      logic k_lt_cnt;
      logic has_room;
      logic match;
      logic rsp_free;
   } ihnm_status_type;

endpackage

/* hw/rtl/ihnm_datapath.sv */
// Datapath: request hold, count and pair memories, search index, result register.
`timescale 1ns / 1ps

module ihnm_datapath #(
   parameter int NUM_VOLUMES     = ihnm_pkg::NUM_VOLUMES_DEF,
   parameter int MAPS_PER_VOLUME = ihnm_pkg::MAPS_PER_VOLUME_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ihnm_pkg::req_word_type         req_word,
   input  logic                           csr_valid,
   input  logic [ihnm_pkg::CNT_W-1:0]     csr_wdata,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output ihnm_pkg::rsp_word_type         rsp_word,
   input  ihnm_pkg::ihnm_cmd_type         cmd,
   output ihnm_pkg::ihnm_status_type      status
);
   import ihnm_pkg::*;

   localparam int VOL_IDX_W = (NUM_VOLUMES > 1) ? $clog2(NUM_VOLUMES) : 1;
   localparam int DEPTH     = NUM_VOLUMES * MAPS_PER_VOLUME;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] MAPS_A = ADDR_W'(MAPS_PER_VOLUME);
   localparam logic [CNT_W-1:0]  MAPS_C = CNT_W'(MAPS_PER_VOLUME);
   localparam logic [6:0]        NVOL_C = 7'(NUM_VOLUMES);

   logic [CNT_W-1:0]   vols_ff;
   req_word_type       req_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [CNT_W-1:0]   k_in;
   logic [CNT_W-1:0]   cnt_mem [NUM_VOLUMES];
   logic               cnt_vld_ff [NUM_VOLUMES];
   logic [CNT_W-1:0]   cnt_rd_ff;
   logic               cnt_vld_rd_ff;
   logic [PAIR_W-1:0]  pair_mem [DEPTH];
   logic [PAIR_W-1:0]  pair_rd_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;

   logic [6:0]           vol_in_ext;
   logic [6:0]           vol_ext;
   logic [VOL_IDX_W-1:0] vol_in_idx;
   logic [VOL_IDX_W-1:0] vol_idx;
   logic [IDX_W-1:0]     entry;
   logic [ADDR_W-1:0]    base_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [PAIR_W-1:0]    req_pair;
   logic                 vol_ok;

   assign vol_in_ext = {3'b000, req_word.volume};
   assign vol_in_idx = vol_in_ext[VOL_IDX_W-1:0];
   assign vol_ext    = {3'b000, req_ff.volume};
   assign vol_idx    = vol_ext[VOL_IDX_W-1:0];
   assign entry      = req_ff.handle[HANDLE_W-1:IDX_LSB];
   assign req_pair   = {req_ff.dev, req_ff.name_space};
   assign base_addr  = ADDR_W'(vol_idx) * MAPS_A;
   assign wr_addr    = base_addr + ADDR_W'(k_ff);
   assign rd_addr    = req_ff.cmd ? (base_addr + ADDR_W'(entry)) : wr_addr;

   assign vol_ok = ({1'b0, req_ff.volume} < vols_ff) && (vol_ext < NVOL_C);

   always_comb begin
      status.reject   = !vol_ok
                        || (!req_ff.cmd && (req_ff.inode == '0))
                        || (req_ff.cmd && (req_ff.handle == '0));
      status.is_rev   = req_ff.cmd;
      status.rev_hit  = ({1'b0, entry} < cnt_ff) && ({1'b0, entry} < MAPS_C);
      status.k_lt_cnt = k_ff < cnt_ff;
      status.has_room = cnt_ff < MAPS_C;
      status.match    = pair_rd_ff == req_pair;
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vols_ff <= '0;
      end else if (csr_valid) begin
         vols_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_word;
      end
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.load_cnt) begin
         k_in = '0;
      end else if (cmd.inc_k) begin
         k_in = k_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (cmd.load_cnt) begin
         cnt_ff <= cnt_vld_rd_ff ? cnt_rd_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff     <= cnt_mem[vol_in_idx];
      cnt_vld_rd_ff <= cnt_vld_ff[vol_in_idx];
      if (cmd.wr_pair) begin
         cnt_mem[vol_idx] <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VOLUMES; i++) begin
            cnt_vld_ff[i] <= 1'b0;
         end
      end else if (cmd.wr_pair) begin
         cnt_vld_ff[vol_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pair_rd_ff <= pair_mem[rd_addr];
      if (cmd.wr_pair) begin
         pair_mem[wr_addr] <= req_pair;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (cmd.rsp_kind)
         RES_FWD: begin
            rsp_in.ok         = 1'b1;
            rsp_in.handle_out = {k_ff[IDX_W-1:0],
                                 (IDX_LSB - INODE_W)'(0), req_ff.inode};
         end
         RES_REV: begin
            rsp_in.ok             = 1'b1;
            rsp_in.inode_out      = req_ff.handle[INODE_W-1:0];
            rsp_in.dev_out        = pair_rd_ff[PAIR_W-1:NS_W];
            rsp_in.name_space_out = pair_rd_ff[NS_W-1:0];
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* hw/rtl/ihnm_ctrl.sv */
// Controller: sequences count lookup, entry search, append and result load.
`timescale 1ns / 1ps

module ihnm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ihnm_pkg::ihnm_status_type status,
   output ihnm_pkg::ihnm_cmd_type    cmd
);
   import ihnm_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_LOOK     = 4'd1;
   localparam logic [3:0] ST_DECIDE   = 4'd2;
   localparam logic [3:0] ST_SREAD    = 4'd3;
   localparam logic [3:0] ST_SCMP     = 4'd4;
   localparam logic [3:0] ST_RWAIT    = 4'd5;
   localparam logic [3:0] ST_FIN_FAIL = 4'd6;
   localparam logic [3:0] ST_FIN_FWD  = 4'd7;
   localparam logic [3:0] ST_FIN_REV  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.load_cnt = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.reject) begin
               state_in = ST_FIN_FAIL;
            end else if (status.is_rev) begin
               state_in = status.rev_hit ? ST_RWAIT : ST_FIN_FAIL;
            end else begin
               state_in = ST_SREAD;
            end
         end
         ST_SREAD: begin
            if (status.k_lt_cnt) begin
               state_in = ST_SCMP;
            end else if (status.has_room) begin
               cmd.wr_pair = 1'b1;
               state_in    = ST_FIN_FWD;
            end else begin
               state_in = ST_FIN_FAIL;
            end
         end
         ST_SCMP: begin
            if (status.match) begin
               state_in = ST_FIN_FWD;
            end else begin
               cmd.inc_k = 1'b1;
               state_in  = ST_SREAD;
            end
         end
         ST_RWAIT: begin
            state_in = ST_FIN_REV;
         end
         ST_FIN_FAIL: begin
            cmd.rsp_kind = RES_FAIL;
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FIN_FWD: begin
            cmd.rsp_kind = RES_FWD;
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FIN_REV: begin
            cmd.rsp_kind = RES_REV;
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/inode_handle_namespace_map.sv */
// Top level of the inode handle namespace map.
`timescale 1ns / 1ps

// Each volume keeps up to MAPS_PER_VOLUME (device, namespace) pairs. A forward
// word (cmd 0) finds or appends its pair and returns handle = index<<28 | inode;
// a reverse word (cmd 1) returns the inode bits of the handle and the pair
// stored at the handle's index. One word is worked on at a time. Its volume's
// entry count is read first; a rejected word, or a reverse word whose index is
// not in use, then fails, a reverse word reads its pair, and a forward word
// reads and compares the stored entries in turn. One that compares all stored
// entries without a match appends its pair, or fails if the table is full. The
// pair memory has one read port, and each entry is read and then compared. A
// result that waits in the output register holds the next result back. A new
// word is taken at the edge after the previous result enters the output register.
// Entry counts clear at reset through per-volume valid bits, so no clearing
// pass is needed. The csr port writes volumes_in_use and is always ready;
// write it only while idle.
module inode_handle_namespace_map #(
   parameter int NUM_VOLUMES     = ihnm_pkg::NUM_VOLUMES_DEF,
   parameter int MAPS_PER_VOLUME = ihnm_pkg::MAPS_PER_VOLUME_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ihnm_pkg::req_word_type     req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ihnm_pkg::rsp_word_type     rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ihnm_pkg::CNT_W-1:0] csr_wdata
);
   import ihnm_pkg::*;

   ihnm_cmd_type    cmd;
   ihnm_status_type status;

   assign csr_ready = 1'b1;

   ihnm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ihnm_datapath #(
      .NUM_VOLUMES     (NUM_VOLUMES),
      .MAPS_PER_VOLUME (MAPS_PER_VOLUME)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_valid (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* hw/rtl/ihnm_checker.sv */
// Port-level checker for the inode handle namespace map, bound to the top level.
`timescale 1ns / 1ps
`include "inode_handle_namespace_map_macros.svh"

module ihnm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input ihnm_pkg::rsp_word_type     rsp_word
);

   `IHNM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "result word changed while stalled")
   `IHNM_ASSERT(a_fail_zero, clock, reset, rsp_valid && !rsp_word.ok |-> rsp_word.handle_out == 0 && rsp_word.inode_out == 0 && rsp_word.dev_out == 0 && rsp_word.name_space_out == 0, "failed result carries nonzero fields")
   `IHNM_ASSERT(a_handle_gap, clock, reset, rsp_valid |-> rsp_word.handle_out[27:24] == 4'd0, "handle has bits between index and inode")
   `IHNM_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while another is in work")
   `IHNM_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

bind inode_handle_namespace_map ihnm_checker u_checker (.*);
